/* hdl/drf_pkg.sv */
// Package: shared types, constants and reason codes of the deadband report filter.
`timescale 1ns / 1ps
package drf_pkg;

  localparam int unsigned CHANNELS   = 64;
  localparam int unsigned SLOTS      = 4;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned CH_W     = 6;
  localparam int unsigned CH_IDX_W = $clog2(CHANNELS);
  localparam int unsigned TS_W     = 63;
  localparam int unsigned TOL_W    = 17;
  localparam int unsigned PERIOD_W = 37;
  localparam int unsigned SUM_W    = TS_W + 1;

  localparam int unsigned SCALE     = 10000;
  localparam int unsigned SCALE_W   = 14;
  localparam int unsigned DIFF_W    = VALUE_BITS + 1;
  localparam int unsigned LHS_W     = DIFF_W + SCALE_W;
  localparam int unsigned RHS_W     = TOL_W + VALUE_BITS;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = PERIOD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE  = 1'b0,
    CFG_MIN_PERIOD = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REASON_DROP   = 2'd0,
    REASON_NEW    = 2'd1,
    REASON_PERIOD = 2'd2,
    REASON_CHANGE = 2'd3
  } reason_e;

  typedef struct packed {
    logic [CH_W-1:0]       channel;
    logic [TS_W-1:0]       timestamp_us;
    logic signed [31:0]    value_0;
    logic signed [31:0]    value_1;
    logic signed [31:0]    value_2;
    logic signed [31:0]    value_3;
    logic [SLOTS-1:0]      present_mask;
  } drf_in_t;

  typedef struct packed {
    logic            forward;
    logic [1:0]      reason;
    logic [CH_W-1:0] out_channel;
  } drf_out_t;

  typedef struct packed {
    logic [SLOTS-1:0][VALUE_BITS-1:0] values;
    logic [SLOTS-1:0]                 mask;
    logic [TS_W-1:0]                  sent_us;
  } drf_entry_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic decide;
  } drf_cmd_t;

endpackage

/* hdl/deadband_report_filter_top.sv */
// Top level: per-channel report-by-exception filter.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------
//  reading  | start_i, busy_o              | in_i (drf_in_t)
//  result   | res_strobe_o (one cycle)     | res_o (drf_out_t)
//  config   | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//
// A reading goes through table read on accept, products registered, then
// decision and table write-back. The result strobe shows in the cycle after
// the decision, when busy_o is already low, so the next start can overlap it.
// Reset clears the known-channel flags and the config registers; stored
// values need no clearing. The receiver cannot stall; config is always ready.
`timescale 1ns / 1ps
module deadband_report_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  drf_pkg::drf_in_t               in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [drf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drf_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output logic                           res_strobe_o,
  output drf_pkg::drf_out_t              res_o
);
  import drf_pkg::*;

  drf_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  drf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  drf_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_i         (in_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

/* hdl/drf_ctrl.sv */
// Controller: sequences capture, product calculation and decision of one word.
`timescale 1ns / 1ps
module drf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output drf_pkg::drf_cmd_t cmd_o
);
  import drf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/drf_datapath.sv */
// Datapath: config registers, channel table, deadband products and decision.
`timescale 1ns / 1ps
module drf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  drf_pkg::drf_cmd_t                   cmd_i,
  input  drf_pkg::drf_in_t                    in_i,
  input  logic                                cfg_we_i,
  input  logic [drf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [drf_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  output logic                                res_strobe_o,
  output drf_pkg::drf_out_t                   res_o
);
  import drf_pkg::*;

  logic [TOL_W-1:0]    tol_q;
  logic [PERIOD_W-1:0] period_q;

  drf_entry_t entry_mem [CHANNELS];
  logic [CHANNELS-1:0] known_q;

  drf_in_t    in_q;
  drf_entry_t rd_q;
  logic       known_rd_q;

  logic [SLOTS-1:0][VALUE_BITS-1:0] new_vals;
  logic [SLOTS-1:0][LHS_W-1:0]      lhs_d, lhs_q;
  logic [SLOTS-1:0][RHS_W-1:0]      rhs_d, rhs_q;
  logic [SLOTS-1:0]                 both_q;
  logic                             period_hit_d, period_hit_q;
  logic [SUM_W-1:0]                 deadline;
  logic [SLOTS-1:0]                 exceed;
  reason_e                          reason;
  logic [CH_IDX_W-1:0]              ch_idx;

  drf_out_t res_q;
  logic     strobe_q;

  assign ch_idx = in_q.channel[CH_IDX_W-1:0];

  assign new_vals[0] = in_q.value_0[VALUE_BITS-1:0];
  assign new_vals[1] = in_q.value_1[VALUE_BITS-1:0];
  assign new_vals[2] = in_q.value_2[VALUE_BITS-1:0];
  assign new_vals[3] = in_q.value_3[VALUE_BITS-1:0];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= '0;
      period_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TOLERANCE:  tol_q    <= cfg_data_i[TOL_W-1:0];
        CFG_MIN_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // |new - old| * SCALE against tol * |old|, one lane per slot
  always_comb begin
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        diff;
    logic [VALUE_BITS-1:0]    ov;
    logic [VALUE_BITS-1:0]    mag;
    for (int s = 0; s < SLOTS; s++) begin
      ov   = rd_q.values[s];
      d    = $signed({new_vals[s][VALUE_BITS-1], new_vals[s]})
             - $signed({ov[VALUE_BITS-1], ov});
      diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      mag  = ov[VALUE_BITS-1] ? VALUE_BITS'(-ov) : ov;
      lhs_d[s] = LHS_W'(diff) * LHS_W'(SCALE);
      rhs_d[s] = RHS_W'(tol_q) * RHS_W'(mag);
    end
  end

  // strictly later than last sent time plus the period
  assign deadline     = SUM_W'(rd_q.sent_us) + SUM_W'(period_q);
  assign period_hit_d = (period_q != '0) && (SUM_W'(in_q.timestamp_us) > deadline);

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      exceed[s] = both_q[s] && (RHS_W'(lhs_q[s]) > rhs_q[s]);
    end
    if (!known_rd_q) begin
      reason = REASON_NEW;
    end else if (period_hit_q) begin
      reason = REASON_PERIOD;
    end else if (|exceed) begin
      reason = REASON_CHANGE;
    end else begin
      reason = REASON_DROP;
    end
  end

  // capture the word and read its channel entry, register the products, then write back the entry and the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_i;
      rd_q <= entry_mem[in_i.channel[CH_IDX_W-1:0]];
    end
    if (cmd_i.calc) begin
      lhs_q        <= lhs_d;
      rhs_q        <= rhs_d;
      both_q       <= in_q.present_mask & rd_q.mask;
      period_hit_q <= period_hit_d;
    end
    if (cmd_i.decide && (reason != REASON_DROP)) begin
      entry_mem[ch_idx] <= '{values: new_vals, mask: in_q.present_mask,
                             sent_us: in_q.timestamp_us};
    end
    if (cmd_i.decide) begin
      res_q.forward     <= (reason != REASON_DROP);
      res_q.reason      <= reason;
      res_q.out_channel <= in_q.channel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q    <= '0;
      known_rd_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      strobe_q <= cmd_i.decide;
      if (cmd_i.capture) begin
        known_rd_q <= known_q[in_i.channel[CH_IDX_W-1:0]];
      end
      if (cmd_i.decide && (reason != REASON_DROP)) begin
        known_q[ch_idx] <= 1'b1;
      end
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

/* hdl/drf_checker.sv */
// Checker: port-level properties of the filter, bound to the top level.
`timescale 1ns / 1ps
module drf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input drf_pkg::drf_in_t          in_i,
  input logic                      res_strobe_o,
  input drf_pkg::drf_out_t         res_o
);
  import drf_pkg::*;

  // each result answers a word accepted earlier, through capture, calculation and decision
  a_strobe_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(start_i && !busy_o, 3))
    else $error("result strobe without matching accepted word");

  a_echo_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.out_channel == $past(in_i.channel, 3)))
    else $error("result channel does not echo the accepted word");

  a_forward_matches_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.forward == (res_o.reason != REASON_DROP)))
    else $error("forward flag disagrees with reason");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after accepting a word");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !busy_o)
    else $error("busy while a result is shown");

endmodule

bind deadband_report_filter_top drf_checker u_drf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .in_i         (in_i),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);
